// ----- sv/a64x_pkg.sv -----
// Package for the A64 subset executor: opcode constants, status codes,
// reset values and the execute result record. No dependencies.
package a64x_pkg;

	localparam int unsigned MEM_WORDS_DEFAULT = 65536;

	localparam logic [63:0] START_PC_RST  = 64'h0000_0000_0040_0000;
	localparam logic [63:0] DATA_BASE_RST = 64'h0000_0000_1000_0000;

	// configuration register indexes
	localparam logic CFG_START_PC  = 1'b0;
	localparam logic CFG_DATA_BASE = 1'b1;

	// status codes
	localparam logic [2:0] ST_EXEC    = 3'd0;
	localparam logic [2:0] ST_HALT    = 3'd1;
	localparam logic [2:0] ST_INVALID = 3'd2;
	localparam logic [2:0] ST_FAULT   = 3'd3;
	localparam logic [2:0] ST_HALTED  = 3'd4;

	// access size codes (log2 of bytes)
	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;
	localparam logic [1:0] SZ_DBL  = 2'd3;

	// opcode fields, top eleven bits
	localparam logic [10:0] OP_ADDS_SR = 11'h558;
	localparam logic [10:0] OP_SUBS_SR = 11'h758;
	localparam logic [10:0] OP_SUBS_ER = 11'h759;
	localparam logic [10:0] OP_ADD_SR  = 11'h458;
	localparam logic [10:0] OP_MUL     = 11'h4D8;
	localparam logic [10:0] OP_HLT     = 11'h6A2;
	localparam logic [10:0] OP_STUR    = 11'h7C0;
	localparam logic [10:0] OP_STURH   = 11'h3C0;
	localparam logic [10:0] OP_STURB   = 11'h1C0;
	localparam logic [10:0] OP_LDUR    = 11'h7C2;
	localparam logic [10:0] OP_LDURH   = 11'h3C2;
	localparam logic [10:0] OP_LDURB   = 11'h1C2;
	// top eight bits
	localparam logic [7:0]  OP_ADDS_I  = 8'hB1;
	localparam logic [7:0]  OP_SUBS_I  = 8'hF1;
	localparam logic [7:0]  OP_ADD_I   = 8'h91;
	localparam logic [7:0]  OP_ANDS    = 8'hEA;
	localparam logic [7:0]  OP_EOR     = 8'hCA;
	localparam logic [7:0]  OP_ORR     = 8'hAA;
	localparam logic [7:0]  OP_CBZ     = 8'hB4;
	localparam logic [7:0]  OP_CBNZ    = 8'hB5;
	localparam logic [7:0]  OP_BCOND   = 8'h54;
	// top nine bits
	localparam logic [8:0]  OP_UBFM    = 9'h1A6;
	localparam logic [8:0]  OP_MOVZ    = 9'h1A5;
	// others
	localparam logic [5:0]  OP_B       = 6'h05;
	localparam logic [21:0] OP_BR      = 22'h3587C0;

	// branch conditions
	localparam logic [3:0] CC_EQ = 4'd0;
	localparam logic [3:0] CC_NE = 4'd1;
	localparam logic [3:0] CC_MI = 4'd4;
	localparam logic [3:0] CC_PL = 4'd5;
	localparam logic [3:0] CC_GE = 4'd10;
	localparam logic [3:0] CC_LT = 4'd11;
	localparam logic [3:0] CC_GT = 4'd12;
	localparam logic [3:0] CC_LE = 4'd13;
	localparam logic [3:0] CC_AL = 4'd14;
	localparam logic [3:0] CC_NV = 4'd15;

	typedef struct packed {
		logic [63:0] npc;
		logic        dest;
		logic [4:0]  rd;
		logic [63:0] val;
		logic        setf;
		logic [2:0]  status;
		logic        halt;
		logic        load;
		logic        store;
		logic        mul;
		logic        mem_ok;
		logic [1:0]  size;
		logic [63:0] off;
		logic [63:0] pp_ll;
		logic [31:0] pp_lh;
		logic [31:0] pp_hl;
	} exec_res_t;

endpackage

// ----- sv/a64x_ram.sv -----
// Generic single-write, single-read RAM with byte enables and registered read.
// No dependencies.
module a64x_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [WIDTH/8-1:0]       be,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write enabled bytes
	always_ff @(posedge clk) begin
		if (we) begin
			for (int i = 0; i < WIDTH/8; i++) begin
				if (be[i]) begin
					mem[waddr][i*8 +: 8] <= wdata[i*8 +: 8];
				end
			end
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/a64x_exec.sv -----
// Decode and execute of one instruction word from registered operands.
// Depends on a64x_pkg.
module a64x_exec import a64x_pkg::*; #(
	parameter int unsigned MEM_WORDS = MEM_WORDS_DEFAULT
) (
	input  logic [31:0] ins,
	input  logic [63:0] a,
	input  logic [63:0] m,
	input  logic [63:0] d,
	input  logic [63:0] pc,
	input  logic        n,
	input  logic        z,
	input  logic        halted,
	input  logic [63:0] base,
	output exec_res_t   res
);

	localparam logic [63:0] LIMIT = 64'(MEM_WORDS) * 64'd4;

	logic [10:0] top11;
	logic [8:0]  top9;
	logic [7:0]  top8;
	logic [5:0]  imm6;
	logic [63:0] imm12;
	logic [63:0] br19;
	logic [63:0] br26;
	logic [63:0] b;
	logic [63:0] addr;
	logic [63:0] bytes;
	logic        aligned;
	logic        take;
	logic        known;

	assign top11 = ins[31:21];
	assign top9  = ins[31:23];
	assign top8  = ins[31:24];
	assign imm6  = ins[15:10];
	assign imm12 = ins[22] ? {40'b0, ins[21:10], 12'b0} : {52'b0, ins[21:10]};
	assign br19  = {{43{ins[23]}}, ins[23:5], 2'b0};
	assign br26  = {{36{ins[25]}}, ins[25:0], 2'b0};
	assign addr  = a + {{55{ins[20]}}, ins[20:12]};

	// shifted and optionally inverted second operand of the logic ops
	always_comb begin
		case (ins[23:22])
			2'd0: b = m << imm6;
			2'd1: b = m >> imm6;
			2'd2: b = 64'($signed(m) >>> imm6);
			default: b = (m >> imm6) | (m << (7'd64 - {1'b0, imm6}));
		endcase
		if (ins[21]) begin
			b = ~b;
		end
	end

	// branch condition on N and Z
	always_comb begin
		take  = 1'b0;
		known = 1'b1;
		case (ins[3:0])
			CC_EQ: take = z;
			CC_NE: take = !z;
			CC_MI, CC_LT: take = n;
			CC_PL, CC_GE: take = !n;
			CC_GT: take = !z && !n;
			CC_LE: take = z || n;
			CC_AL, CC_NV: take = 1'b1;
			default: known = 1'b0;
		endcase
	end

	// main decode
	always_comb begin
		res        = '0;
		res.npc    = pc + 64'd4;
		res.status = ST_EXEC;
		res.rd     = ins[4:0];
		res.pp_ll  = 64'(a[31:0]) * 64'(m[31:0]);
		res.pp_lh  = a[31:0] * m[63:32];
		res.pp_hl  = a[63:32] * m[31:0];
		res.size   = (top11[10:9] == 2'b11) ? SZ_DBL : (top11[9] ? SZ_HALF : SZ_BYTE);
		res.off    = addr - base;
		if (halted) begin
			res.npc    = pc;
			res.status = ST_HALTED;
		end else if (top11 == OP_ADDS_SR) begin
			res.val = a + (m << imm6); res.dest = 1'b1; res.setf = 1'b1;
		end else if (top11 == OP_SUBS_SR) begin
			res.val = a - (m << imm6); res.dest = 1'b1; res.setf = 1'b1;
		end else if (top11 == OP_SUBS_ER) begin
			res.val = a - (m << ins[12:10]); res.dest = 1'b1; res.setf = 1'b1;
		end else if (top11 == OP_ADD_SR) begin
			res.val = a + (m << imm6); res.dest = 1'b1;
		end else if (top11 == OP_MUL) begin
			res.mul = 1'b1; res.dest = 1'b1;
		end else if (top11 == OP_HLT) begin
			res.halt = 1'b1; res.status = ST_HALT;
		end else if (top11 inside {OP_STUR, OP_STURH, OP_STURB, OP_LDUR, OP_LDURH,
				OP_LDURB}) begin
			res.load  = top11[1];
			res.store = !top11[1];
		end else if (top8 == OP_ADDS_I) begin
			res.val = a + imm12; res.dest = 1'b1; res.setf = 1'b1;
		end else if (top8 == OP_SUBS_I) begin
			res.val = a - imm12; res.dest = 1'b1; res.setf = 1'b1;
		end else if (top8 == OP_ADD_I) begin
			res.val = a + imm12; res.dest = 1'b1;
		end else if (top8 inside {OP_ANDS, OP_EOR, OP_ORR}) begin
			res.val  = (top8 == OP_ANDS) ? (a & b) : (top8 == OP_EOR) ? (a ^ b) : (a | b);
			res.dest = 1'b1;
			res.setf = (top8 == OP_ANDS);
		end else if (top9 == OP_UBFM) begin
			res.val  = (imm6 != 6'd63) ? (a << (6'd63 - imm6)) : (a >> ins[21:16]);
			res.dest = 1'b1;
		end else if (top9 == OP_MOVZ) begin
			res.val  = {48'b0, ins[20:5]} << {ins[22:21], 4'b0};
			res.dest = 1'b1;
		end else if (ins[31:26] == OP_B) begin
			res.npc = pc + br26;
		end else if (ins[31:10] == OP_BR) begin
			res.npc = a;
		end else if (top8 == OP_CBZ || top8 == OP_CBNZ) begin
			if ((d == 64'd0) == (top8 == OP_CBZ)) begin
				res.npc = pc + br19;
			end
		end else if (top8 == OP_BCOND) begin
			if (!known) begin
				res.status = ST_INVALID;
			end else if (take) begin
				res.npc = pc + br19;
			end
		end else begin
			res.status = ST_INVALID;
		end

		// range and alignment check of a memory access
		bytes   = 64'd1 << res.size;
		aligned = (res.size == SZ_DBL) ? (addr[2:0] == 3'd0) :
			(res.size == SZ_HALF) ? !addr[0] : 1'b1;
		res.mem_ok = aligned && (res.off <= LIMIT - bytes);
		if ((res.load || res.store) && !res.mem_ok) begin
			res.status = ST_FAULT;
			res.npc    = pc;
		end
		if (res.load) begin
			res.dest = res.mem_ok;
		end
	end

endmodule

// ----- sv/a64_subset_instruction_executor_top.sv -----
// Top level of the A64 subset executor: handshakes, pipeline, register file,
// data memory and state. Depends on a64x_pkg, a64x_ram and a64x_exec.
//
// Use: send one instruction word per in_valid/in_ready handshake; each word
// gives exactly one result word on out_valid/out_ready, in order. Config
// writes (cfg_index 0: start_pc, also loads the PC; 1: data_base) are taken
// with cfg_valid high while no word sits in the execute stage, and must only
// be sent while idle.
// Most instructions finish in the execute stage and go straight to the output
// register; MUL and loads pass through the second stage, which finishes the
// multiply partial sums and the registered data memory read. Throughput: one
// word per cycle for ordinary instructions while the output is not stalled;
// after a MUL or a load the next word is taken only as that one commits.
// Reset: the register file and data memory are zeroed by a clearing pass, one
// 64-bit row in each of the two memory banks per cycle, with in_ready low.
// A stalled receiver is absorbed by the output register; the pipeline then
// holds and in_ready drops.
module a64_subset_instruction_executor_top import a64x_pkg::*; #(
	parameter int unsigned MEM_WORDS = MEM_WORDS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] instruction,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] next_pc,
	output logic        reg_write,
	output logic [4:0]  reg_index,
	output logic [63:0] reg_value,
	output logic        flag_n,
	output logic        flag_z,
	output logic [2:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int unsigned ROWS = (MEM_WORDS + 1) / 2;
	localparam int unsigned RAW  = $clog2(ROWS);
	localparam int unsigned BANK = (ROWS + 1) / 2;
	localparam int unsigned BAW  = $clog2(BANK);

	// architectural state
	logic [63:0] pc_q, base_q;
	logic        n_q, z_q, halted_q;
	logic        clr_q;
	logic [BAW-1:0] cnt_q;

	// stage 1
	logic        vld_s1;
	logic [31:0] ins_s1;
	logic        hit_a_s1, hit_m_s1, hit_d_s1;
	logic [63:0] bv_a_s1, bv_m_s1, bv_d_s1;
	logic [63:0] rf_a, rf_m, rf_d;
	logic [63:0] op_a, op_m, op_d;
	exec_res_t   er;

	// stage 2
	logic        vld_s2, load_s2, dest_s2;
	logic [4:0]  rd_s2;
	logic [2:0]  lane_s2;
	logic        par_s2;
	logic [1:0]  size_s2;
	logic [63:0] pp_ll_s2;
	logic [31:0] pp_lh_s2, pp_hl_s2;
	logic [63:0] npc_s2;
	logic        n_s2, z_s2;
	logic [2:0]  st_s2;
	logic [127:0] ld_wide;
	logic [63:0] ld_val, val_s2;

	// output
	logic        out_valid_q;

	// handshake control
	logic s1_long, s1_adv, s1_fin, s2_commit, out_free, accept;
	logic wr1, wr2, rf_we;
	logic [4:0]  rf_waddr;
	logic [63:0] rf_wdata;

	// data memory banks
	logic [RAW:0]   row_lo, row_hi;
	logic [BAW-1:0] addr_e, addr_o;
	logic [127:0]   st_wide;
	logic [15:0]    be_wide;
	logic [63:0]    wd_e, wd_o, rd_e, rd_o;
	logic [7:0]     be_e, be_o;
	logic           dm_we, dm_re;

	assign out_free  = !out_valid_q || out_ready;
	assign s1_long   = er.load || er.mul;
	assign s2_commit = vld_s2 && out_free;
	assign s1_adv    = vld_s1 && (s1_long ? (!vld_s2 || s2_commit) : out_free);
	assign s1_fin    = s1_adv && !s1_long;
	assign in_ready  = !clr_q && (!vld_s1 || s1_fin) && (!vld_s2 || s2_commit);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = !vld_s1;

	// register file writes from either stage, or zero while clearing
	assign wr1 = s1_fin && er.dest && (er.rd != 5'd31);
	assign wr2 = s2_commit && dest_s2 && (rd_s2 != 5'd31);
	always_comb begin
		rf_we    = clr_q || wr1 || wr2;
		rf_waddr = clr_q ? cnt_q[4:0] : (wr2 ? rd_s2 : er.rd);
		rf_wdata = clr_q ? 64'd0 : (wr2 ? val_s2 : er.val);
	end

	a64x_ram #(.WIDTH(64), .DEPTH(32)) u_rf_a (
		.clk(clk), .we(rf_we), .be(8'hFF), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(accept), .raddr(instruction[9:5]), .rdata(rf_a)
	);
	a64x_ram #(.WIDTH(64), .DEPTH(32)) u_rf_m (
		.clk(clk), .we(rf_we), .be(8'hFF), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(accept), .raddr(instruction[20:16]), .rdata(rf_m)
	);
	a64x_ram #(.WIDTH(64), .DEPTH(32)) u_rf_d (
		.clk(clk), .we(rf_we), .be(8'hFF), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(accept), .raddr(instruction[4:0]), .rdata(rf_d)
	);

	// operands with the bypass captured at acceptance
	assign op_a = hit_a_s1 ? bv_a_s1 : rf_a;
	assign op_m = hit_m_s1 ? bv_m_s1 : rf_m;
	assign op_d = hit_d_s1 ? bv_d_s1 : rf_d;

	a64x_exec #(.MEM_WORDS(MEM_WORDS)) u_exec (
		.ins(ins_s1), .a(op_a), .m(op_m), .d(op_d), .pc(pc_q), .n(n_q), .z(z_q),
		.halted(halted_q), .base(base_q), .res(er)
	);

	// data memory as even and odd 64-bit row banks, so an access that
	// straddles a row boundary touches both rows in one cycle
	always_comb begin
		row_lo  = {1'b0, er.off[RAW+2:3]};
		row_hi  = row_lo + 1'b1;
		addr_o  = row_lo[BAW:1];
		addr_e  = row_lo[0] ? row_hi[BAW:1] : row_lo[BAW:1];
		st_wide = {64'd0, op_d} << {er.off[2:0], 3'b0};
		case (er.size)
			SZ_BYTE: be_wide = 16'h0001 << er.off[2:0];
			SZ_HALF: be_wide = 16'h0003 << er.off[2:0];
			default: be_wide = 16'h00FF << er.off[2:0];
		endcase
		wd_e  = row_lo[0] ? st_wide[127:64] : st_wide[63:0];
		wd_o  = row_lo[0] ? st_wide[63:0] : st_wide[127:64];
		be_e  = row_lo[0] ? be_wide[15:8] : be_wide[7:0];
		be_o  = row_lo[0] ? be_wide[7:0] : be_wide[15:8];
		dm_we = s1_adv && er.store && er.mem_ok;
		if (clr_q) begin
			addr_e = cnt_q;
			addr_o = cnt_q;
			wd_e   = 64'd0;
			wd_o   = 64'd0;
			be_e   = 8'hFF;
			be_o   = 8'hFF;
			dm_we  = 1'b1;
		end
	end

	assign dm_re = s1_adv && er.load && er.mem_ok;

	a64x_ram #(.WIDTH(64), .DEPTH(BANK)) u_dmem_e (
		.clk(clk), .we(dm_we), .be(be_e), .waddr(addr_e), .wdata(wd_e),
		.re(dm_re), .raddr(addr_e), .rdata(rd_e)
	);
	a64x_ram #(.WIDTH(64), .DEPTH(BANK)) u_dmem_o (
		.clk(clk), .we(dm_we), .be(be_o), .waddr(addr_o), .wdata(wd_o),
		.re(dm_re), .raddr(addr_o), .rdata(rd_o)
	);

	// finish a load or a multiply
	always_comb begin
		ld_wide = (par_s2 ? {rd_e, rd_o} : {rd_o, rd_e}) >> {lane_s2, 3'b0};
		ld_val  = ld_wide[63:0];
		case (size_s2)
			SZ_BYTE: ld_val = ld_val & 64'hFF;
			SZ_HALF: ld_val = ld_val & 64'hFFFF;
			default: ld_val = ld_val;
		endcase
		val_s2 = load_s2 ? ld_val : (pp_ll_s2 + {pp_lh_s2 + pp_hl_s2, 32'b0});
	end

	// stage 1 capture with bypass of same-edge writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (s1_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ins_s1   <= instruction;
			hit_a_s1 <= (wr1 && er.rd == instruction[9:5]) ||
				(wr2 && rd_s2 == instruction[9:5]);
			hit_m_s1 <= (wr1 && er.rd == instruction[20:16]) ||
				(wr2 && rd_s2 == instruction[20:16]);
			hit_d_s1 <= (wr1 && er.rd == instruction[4:0]) ||
				(wr2 && rd_s2 == instruction[4:0]);
			bv_a_s1  <= wr1 ? er.val : val_s2;
			bv_m_s1  <= wr1 ? er.val : val_s2;
			bv_d_s1  <= wr1 ? er.val : val_s2;
		end
	end

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s1_adv && s1_long) begin
			vld_s2 <= 1'b1;
		end else if (s2_commit) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_long) begin
			load_s2  <= er.load;
			dest_s2  <= er.dest;
			rd_s2    <= er.rd;
			lane_s2  <= er.off[2:0];
			par_s2   <= row_lo[0];
			size_s2  <= er.size;
			pp_ll_s2 <= er.pp_ll;
			pp_lh_s2 <= er.pp_lh;
			pp_hl_s2 <= er.pp_hl;
			npc_s2   <= er.npc;
			n_s2     <= n_q;
			z_s2     <= z_q;
			st_s2    <= er.status;
		end
	end

	// architectural state, clearing pass and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= START_PC_RST;
			base_q   <= DATA_BASE_RST;
			n_q      <= 1'b0;
			z_q      <= 1'b0;
			halted_q <= 1'b0;
			clr_q    <= 1'b1;
			cnt_q    <= '0;
		end else begin
			if (clr_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == BAW'(BANK - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (s1_adv) begin
				pc_q <= er.npc;
				if (er.setf) begin
					n_q <= er.val[63];
					z_q <= (er.val == 64'd0);
				end
				if (er.halt) begin
					halted_q <= 1'b1;
				end
			end else if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_START_PC:  pc_q   <= cfg_data;
					CFG_DATA_BASE: base_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fin || s2_commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_commit) begin
			next_pc   <= npc_s2;
			reg_write <= dest_s2;
			reg_index <= dest_s2 ? rd_s2 : 5'd0;
			reg_value <= dest_s2 ? val_s2 : 64'd0;
			flag_n    <= n_s2;
			flag_z    <= z_s2;
			status    <= st_s2;
		end else if (s1_fin) begin
			next_pc   <= er.npc;
			reg_write <= er.dest;
			reg_index <= er.dest ? er.rd : 5'd0;
			reg_value <= er.dest ? er.val : 64'd0;
			flag_n    <= er.setf ? er.val[63] : n_q;
			flag_z    <= er.setf ? (er.val == 64'd0) : z_q;
			status    <= er.status;
		end
	end

	assign out_valid = out_valid_q;

	// checks
	a_one_rf_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr1 && wr2)) else $error("two register file writers in one cycle");
	a_s2_free_for_long: assert property (@(posedge clk) disable iff (!arst_n)
		!(vld_s1 && vld_s2 && s1_long)) else $error("long op entered busy stage 2");
	a_long_reaches_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && s1_long) |=> vld_s2) else $error("long op lost");
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !in_ready) else $error("word accepted during clearing pass");

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for the A64 subset executor: drives instruction words,
// predicts every result in its own machine model and checks each result word.
// Depends on a64x_pkg and a64_subset_instruction_executor_top.
`timescale 1ns / 1ps

module testbench;
	import a64x_pkg::*;

	localparam int unsigned MW        = MEM_WORDS_DEFAULT;
	localparam logic [63:0] WIN_BYTES = 64'(MW) * 64'd4;
	localparam int          CYC_LIMIT = 600000;
	localparam int          RAND_PER  = 270;

	typedef struct {
		logic [63:0] npc;
		logic        wr;
		logic [4:0]  idx;
		logic [63:0] val;
		logic        n;
		logic        z;
		logic [2:0]  st;
	} retire_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] instruction = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] next_pc;
	logic        reg_write;
	logic [4:0]  reg_index;
	logic [63:0] reg_value;
	logic        flag_n;
	logic        flag_z;
	logic [2:0]  status;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [63:0] cfg_data = '0;

	// machine model state
	logic [63:0] xreg [31];
	logic [63:0] m_pc;
	logic        m_n, m_z, m_halted;
	logic [31:0] dmem [MW];
	logic [63:0] m_start_pc, m_data_base;

	logic [31:0] word_q [$];
	retire_t     retire_q [$];

	int errors = 0;
	int words_sent = 0;
	int results_seen = 0;
	int faults_seen = 0;
	int halted_seen = 0;
	int cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	bit long_hold_done = 0;

	a64_subset_instruction_executor_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .instruction(instruction),
		.out_valid(out_valid), .out_ready(out_ready),
		.next_pc(next_pc), .reg_write(reg_write), .reg_index(reg_index),
		.reg_value(reg_value), .flag_n(flag_n), .flag_z(flag_z), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [63:0] xr(input logic [4:0] i);
		return (i == 5'd31) ? 64'd0 : xreg[i];
	endfunction

	function automatic logic [63:0] shift_by(input logic [63:0] v, input logic [1:0] kind,
			input logic [5:0] amt);
		if (amt == 0)
			return v;
		case (kind)
			2'd0: return v << amt;
			2'd1: return v >> amt;
			2'd2: return $unsigned($signed(v) >>> amt);
			default: return (v >> amt) | (v << (7'd64 - amt));
		endcase
	endfunction

	// execute one word on the model and queue the result it must give
	function automatic void execute_word(input logic [31:0] ins);
		logic [10:0] op11;
		logic [7:0]  op8;
		logic [8:0]  op9;
		logic [4:0]  rd;
		logic [5:0]  imm6;
		logic [63:0] imm12, a, b, val, npc, addr, off, sz, o;
		logic [63:0] br19;
		logic        dest, setf, ld, st_op, take, known;
		logic [2:0]  st;
		retire_t     r;
		op11 = ins[31:21];
		op8 = ins[31:24];
		op9 = ins[31:23];
		rd = ins[4:0];
		imm6 = ins[15:10];
		imm12 = ins[22] ? {40'd0, ins[21:10], 12'd0} : {52'd0, ins[21:10]};
		a = xr(ins[9:5]);
		val = '0;
		npc = m_pc + 64'd4;
		sz = '0;
		dest = 0; setf = 0; ld = 0; st_op = 0;
		st = ST_EXEC;
		br19 = {{43{ins[23]}}, ins[23:5], 2'b00};
		if (m_halted) begin
			npc = m_pc;
			st = ST_HALTED;
		end else if (op11 == OP_ADDS_SR) begin
			val = a + (xr(ins[20:16]) << imm6); dest = 1; setf = 1;
		end else if (op11 == OP_SUBS_SR) begin
			val = a - (xr(ins[20:16]) << imm6); dest = 1; setf = 1;
		end else if (op11 == OP_SUBS_ER) begin
			val = a - (xr(ins[20:16]) << ins[12:10]); dest = 1; setf = 1;
		end else if (op11 == OP_ADD_SR) begin
			val = a + (xr(ins[20:16]) << imm6); dest = 1;
		end else if (op11 == OP_MUL) begin
			val = a * xr(ins[20:16]); dest = 1;
		end else if (op11 == OP_HLT) begin
			m_halted = 1; st = ST_HALT;
		end else if (op11 inside {OP_STUR, OP_STURH, OP_STURB, OP_LDUR, OP_LDURH, OP_LDURB}) begin
			sz = (op11[10:9] == 2'b11) ? 64'd8 : (op11[9] ? 64'd2 : 64'd1);
			ld = op11[1];
			st_op = !op11[1];
		end else if (op8 == OP_ADDS_I) begin
			val = a + imm12; dest = 1; setf = 1;
		end else if (op8 == OP_SUBS_I) begin
			val = a - imm12; dest = 1; setf = 1;
		end else if (op8 == OP_ADD_I) begin
			val = a + imm12; dest = 1;
		end else if (op8 == OP_ANDS || op8 == OP_EOR || op8 == OP_ORR) begin
			b = shift_by(xr(ins[20:16]), ins[23:22], imm6);
			if (ins[21])
				b = ~b;
			val = (op8 == OP_ANDS) ? (a & b) : (op8 == OP_EOR) ? (a ^ b) : (a | b);
			dest = 1;
			setf = (op8 == OP_ANDS);
		end else if (op9 == OP_UBFM) begin
			val = (imm6 != 6'd63) ? (a << (6'd63 - imm6)) : (a >> ins[21:16]);
			dest = 1;
		end else if (op9 == OP_MOVZ) begin
			val = {48'd0, ins[20:5]} << (7'd16 * ins[22:21]);
			dest = 1;
		end else if (ins[31:26] == OP_B) begin
			npc = m_pc + {{36{ins[25]}}, ins[25:0], 2'b00};
		end else if (ins[31:10] == OP_BR) begin
			npc = a;
		end else if (op8 == OP_CBZ || op8 == OP_CBNZ) begin
			if ((xr(rd) == 0) == (op8 == OP_CBZ))
				npc = m_pc + br19;
		end else if (op8 == OP_BCOND) begin
			known = 1;
			take = 0;
			case (ins[3:0])
				CC_EQ: take = m_z;
				CC_NE: take = !m_z;
				CC_MI: take = m_n;
				CC_PL: take = !m_n;
				CC_GE: take = !m_n;
				CC_LT: take = m_n;
				CC_GT: take = !m_z && !m_n;
				CC_LE: take = m_z || m_n;
				CC_AL, CC_NV: take = 1;
				default: known = 0;
			endcase
			if (!known)
				st = ST_INVALID;
			else if (take)
				npc = m_pc + br19;
		end else begin
			st = ST_INVALID;
		end
		// data memory access, little-endian bytes within words
		if (ld || st_op) begin
			addr = a + {{55{ins[20]}}, ins[20:12]};
			off = addr - m_data_base;
			if ((addr & (sz - 64'd1)) != 0 || off > WIN_BYTES - sz) begin
				st = ST_FAULT;
				npc = m_pc;
			end else if (st_op) begin
				b = xr(rd);
				for (int i = 0; i < int'(sz); i++) begin
					o = off + 64'(i);
					dmem[(o >> 2) % MW][o[1:0]*8 +: 8] = b[8*i +: 8];
				end
			end else begin
				for (int i = 0; i < int'(sz); i++) begin
					o = off + 64'(i);
					val[8*i +: 8] = dmem[(o >> 2) % MW][o[1:0]*8 +: 8];
				end
				dest = 1;
			end
		end
		if (setf) begin
			m_n = val[63];
			m_z = (val == 0);
		end
		if (dest && rd != 5'd31)
			xreg[rd] = val;
		m_pc = npc;
		r.npc = npc;
		r.wr = dest;
		r.idx = dest ? rd : 5'd0;
		r.val = dest ? val : 64'd0;
		r.n = m_n;
		r.z = m_z;
		r.st = st;
		retire_q.push_back(r);
	endfunction

	function automatic void queue_word(input logic [31:0] w);
		word_q.push_back(w);
		execute_word(w);
	endfunction

	// encoders for the instruction formats
	function automatic logic [31:0] enc_r(input logic [10:0] op, input logic [4:0] rm,
			input logic [5:0] i6, input logic [4:0] rn, input logic [4:0] rd);
		return {op, rm, i6, rn, rd};
	endfunction

	function automatic logic [31:0] enc_i(input logic [7:0] op, input logic sh,
			input logic [11:0] i12, input logic [4:0] rn, input logic [4:0] rd);
		return {op, 1'b0, sh, i12, rn, rd};
	endfunction

	function automatic logic [31:0] enc_l(input logic [7:0] op, input logic [1:0] sk,
			input logic inv, input logic [4:0] rm, input logic [5:0] i6,
			input logic [4:0] rn, input logic [4:0] rd);
		return {op, sk, inv, rm, i6, rn, rd};
	endfunction

	function automatic logic [31:0] enc_m(input logic [10:0] op, input logic [8:0] s9,
			input logic [4:0] rn, input logic [4:0] rt);
		return {op, s9, 2'b00, rn, rt};
	endfunction

	function automatic logic [31:0] enc_movz(input logic [1:0] hw, input logic [15:0] i16,
			input logic [4:0] rd);
		return {OP_MOVZ, hw, i16, rd};
	endfunction

	function automatic logic [31:0] enc_bc(input logic [18:0] i19, input logic [3:0] cc);
		return {OP_BCOND, i19, 1'b0, cc};
	endfunction

	// destination mostly outside the pointer registers X23..X27
	function automatic logic [4:0] dst_reg();
		logic [4:0] r;
		r = 5'($urandom_range(0, 31));
		if ($urandom_range(0, 49) != 0 && r >= 23 && r <= 27)
			r = 5'($urandom_range(0, 22));
		return r;
	endfunction

	// load X27 with data_base and X24..X26 with the window start, middle and 256 bytes before its end
	task automatic load_pointers();
		queue_word(enc_movz(2'd0, m_data_base[15:0], 5'd27));
		for (int h = 1; h < 4; h++) begin
			queue_word(enc_movz(2'(h), m_data_base[16*h +: 16], 5'd23));
			queue_word(enc_l(OP_ORR, 2'd0, 1'b0, 5'd23, 6'd0, 5'd27, 5'd27));
		end
		queue_word(enc_i(OP_ADD_I, 1'b0, 12'd0, 5'd27, 5'd24));
		queue_word(enc_i(OP_ADD_I, 1'b1, 12'((WIN_BYTES >> 13)), 5'd27, 5'd25));
		queue_word(enc_i(OP_ADD_I, 1'b1, 12'(((WIN_BYTES - 64'd256) >> 12)), 5'd27, 5'd26));
		queue_word(enc_i(OP_ADD_I, 1'b0, 12'((WIN_BYTES - 64'd256) & 64'hF00), 5'd26, 5'd26));
	endtask

	function automatic logic [31:0] random_word();
		int k;
		logic [31:0] w;
		logic [10:0] mops [6];
		logic [10:0] aops [4];
		logic [7:0]  iops [3];
		logic [7:0]  lops [3];
		logic [8:0]  s9;
		logic [10:0] mop;
		logic [4:0]  rn;
		mops = '{OP_STUR, OP_STURH, OP_STURB, OP_LDUR, OP_LDURH, OP_LDURB};
		aops = '{OP_ADDS_SR, OP_SUBS_SR, OP_SUBS_ER, OP_ADD_SR};
		iops = '{OP_ADDS_I, OP_SUBS_I, OP_ADD_I};
		lops = '{OP_ANDS, OP_EOR, OP_ORR};
		k = $urandom_range(0, 99);
		if (k < 10) begin
			do w = $urandom(); while (w[31:21] == OP_HLT);
		end else if (k < 20)
			w = enc_r(aops[$urandom_range(0, 3)], 5'($urandom), 6'($urandom), 5'($urandom),
				dst_reg());
		else if (k < 28)
			w = enc_i(iops[$urandom_range(0, 2)], 1'($urandom), 12'($urandom), 5'($urandom),
				dst_reg());
		else if (k < 36)
			w = enc_l(lops[$urandom_range(0, 2)], 2'($urandom), 1'($urandom), 5'($urandom),
				6'($urandom), 5'($urandom), dst_reg());
		else if (k < 40)
			w = {OP_MUL, 5'($urandom), 6'($urandom), 5'($urandom), dst_reg()};
		else if (k < 46)
			w = {OP_UBFM, 1'b1, 6'($urandom), ($urandom_range(0, 3) == 0) ? 6'd63 : 6'($urandom),
				5'($urandom), dst_reg()};
		else if (k < 52)
			w = enc_movz(2'($urandom), 16'($urandom), dst_reg());
		else if (k < 76) begin
			mop = mops[$urandom_range(0, 5)];
			s9 = 9'($urandom);
			// mostly aligned accesses near the window start, middle and end
			if ($urandom_range(0, 7) != 0)
				s9 = (mop[10:9] == 2'b11) ? {s9[8:3], 3'b000} :
					(mop[9] ? {s9[8:1], 1'b0} : s9);
			rn = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(24, 26));
			w = enc_m(mop, s9, rn, mop[1] ? dst_reg() : 5'($urandom));
		end else if (k < 80)
			w = {OP_B, ($urandom_range(0, 4) == 0) ? 26'($urandom) :
				26'($signed(10'($urandom)))};
		else if (k < 82)
			w = {OP_BR, 5'($urandom), 5'($urandom)};
		else if (k < 88)
			w = {$urandom_range(0, 1) ? OP_CBZ : OP_CBNZ, 19'($signed(8'($urandom))),
				5'($urandom)};
		else if (k < 96)
			w = enc_bc(19'($signed(8'($urandom))), 4'($urandom));
		else
			w = enc_r(OP_SUBS_SR, 5'($urandom), 6'd0, 5'($urandom), 5'd31);
		return w;
	endfunction

	task automatic write_cfg(input logic idx, input logic [63:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_START_PC) begin
			m_start_pc = data;
			m_pc = data;
		end else begin
			m_data_base = data;
		end
	endtask

	task automatic wait_idle();
		while (word_q.size() != 0 || in_valid || retire_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic directed_words();
		load_pointers();
		// MOVZ in every halfword slot, then arithmetic extremes
		for (int h = 0; h < 4; h++)
			queue_word(enc_movz(2'(h), 16'hFFFF, 5'(h)));
		queue_word(enc_l(OP_ORR, 2'd0, 1'b1, 5'd31, 6'd0, 5'd31, 5'd4));
		queue_word(enc_i(OP_ADDS_I, 1'b0, 12'd1, 5'd4, 5'd5));
		queue_word(enc_r(OP_SUBS_SR, 5'd4, 6'd63, 5'd31, 5'd6));
		queue_word(enc_r(OP_SUBS_ER, 5'd3, 6'd7, 5'd2, 5'd31));
		queue_word(enc_r(OP_ADD_SR, 5'd1, 6'd1, 5'd0, 5'd7));
		queue_word({OP_MUL, 5'd4, 6'h3F, 5'd3, 5'd8});
		queue_word(enc_l(OP_ANDS, 2'd3, 1'b0, 5'd3, 6'd17, 5'd4, 5'd9));
		queue_word(enc_l(OP_EOR, 2'd2, 1'b1, 5'd3, 6'd63, 5'd1, 5'd10));
		queue_word({OP_UBFM, 1'b1, 6'd0, 6'd0, 5'd4, 5'd11});
		queue_word({OP_UBFM, 1'b1, 6'd63, 6'd63, 5'd4, 5'd12});
		// stores then narrow merges and loads at both window ends
		queue_word(enc_m(OP_STUR, 9'd0, 5'd24, 5'd3));
		queue_word(enc_m(OP_STURB, 9'd1, 5'd24, 5'd4));
		queue_word(enc_m(OP_STURH, 9'd6, 5'd24, 5'd31));
		queue_word(enc_m(OP_LDUR, 9'd0, 5'd24, 5'd13));
		queue_word(enc_m(OP_LDURH, 9'd2, 5'd24, 5'd14));
		queue_word(enc_m(OP_STUR, 9'd248, 5'd26, 5'd4));
		queue_word(enc_m(OP_LDURB, 9'd255, 5'd26, 5'd15));
		queue_word(enc_m(OP_LDUR, 9'd3, 5'd24, 5'd16));
		queue_word(enc_m(OP_LDURB, 9'h1FF, 5'd24, 5'd16));
		// branches: backward B, BR, CBZ/CBNZ, a carry condition, NV (always taken)
		queue_word({OP_B, 26'h3FFFFFF});
		queue_word({OP_BR, 5'd4, 5'd0});
		queue_word({OP_CBZ, 19'h7FFFF, 5'd31});
		queue_word({OP_CBNZ, 19'h40000, 5'd4});
		queue_word(enc_bc(19'd4, 4'd2));
		queue_word(enc_bc(19'd4, CC_NV));
	endtask

	// stimulus and configuration phases
	initial begin
		logic [63:0] sp [5];
		logic [63:0] db [5];
		for (int i = 0; i < 31; i++)
			xreg[i] = '0;
		for (int i = 0; i < MW; i++)
			dmem[i] = '0;
		m_start_pc = START_PC_RST;
		m_data_base = DATA_BASE_RST;
		m_pc = START_PC_RST;
		m_n = 0; m_z = 0; m_halted = 0;
		sp = '{START_PC_RST, 64'd0, '1, {$urandom, $urandom}, 64'h0000_0000_0010_0000};
		db = '{DATA_BASE_RST, 64'd0, '1 - WIN_BYTES + 64'd1, {$urandom, $urandom & ~32'h3},
			'1};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 5; p++) begin
			if (p > 0) begin
				write_cfg(CFG_START_PC, sp[p]);
				write_cfg(CFG_DATA_BASE, db[p]);
			end
			if (p == 0)
				directed_words();
			else
				load_pointers();
			for (int i = 0; i < RAND_PER; i++) begin
				if (i % 60 == 0)
					load_pointers();
				queue_word(random_word());
			end
			if (p == 4) begin
				queue_word({OP_HLT, 16'($urandom), 5'd0});
				for (int i = 0; i < 12; i++)
					queue_word(random_word());
			end
			wait_idle();
		end
		$display("Run covered %0d instruction words over 5 configuration settings,", words_sent);
		$display("%0d results checked, %0d memory faults, %0d words after halt.",
			results_seen, faults_seen, halted_seen);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// send words in bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				words_sent++;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (word_q.size() != 0) begin
				instruction <= word_q.pop_front();
				in_valid <= 1'b1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// stall the result side; hold off for a long stretch once, early on
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!long_hold_done && results_seen >= 100) begin
			long_hold_done = 1;
			hold_left = 200;
			out_ready <= 1'b0;
		end else if (cycles[8:6] == 3'd0) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic report(input string fld, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch on result %0d: %s got %h want %h", results_seen, fld, got, want);
	endtask

	// check each result word against the oldest prediction
	always @(posedge clk) begin
		retire_t e;
		if (arst_n && out_valid && out_ready) begin
			if (retire_q.size() == 0) begin
				report("unexpected result", next_pc, 64'd0);
			end else begin
				e = retire_q.pop_front();
				if (next_pc !== e.npc) report("next_pc", next_pc, e.npc);
				if (reg_write !== e.wr) report("reg_write", 64'(reg_write), 64'(e.wr));
				if (reg_index !== e.idx) report("reg_index", 64'(reg_index), 64'(e.idx));
				if (reg_value !== e.val) report("reg_value", reg_value, e.val);
				if (flag_n !== e.n) report("flag_n", 64'(flag_n), 64'(e.n));
				if (flag_z !== e.z) report("flag_z", 64'(flag_z), 64'(e.z));
				if (status !== e.st) report("status", 64'(status), 64'(e.st));
				if (e.st == ST_FAULT) faults_seen++;
				if (e.st == ST_HALTED) halted_seen++;
			end
			results_seen++;
		end
	end

	// bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYC_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

endmodule

// ----- sim.f -----
sv/a64x_pkg.sv
sv/a64x_ram.sv
sv/a64x_exec.sv
sv/a64_subset_instruction_executor_top.sv
tb/testbench.sv
